// ===== sv/positional_list_engine_unit_assert.svh =====
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ple_pkg.sv =====
package ple_pkg;

    localparam int DEPTH  = 64;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = 8;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_DEL_POS   = 3'd5,
        MODE_LIST      = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic list_step;
        logic list_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              slot_free;
    } stat_t;

endpackage

// ===== sv/ple_ctrl.sv =====
`include "positional_list_engine_unit_assert.svh"

module ple_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ple_pkg::mode_t mode,
    input  ple_pkg::stat_t stat,
    output ple_pkg::cmd_t  cmd
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              accept;
    logic              start_list;

    assign in_ready   = (state_reg == ST_IDLE) && stat.slot_free;
    assign accept     = in_valid && in_ready;
    assign start_list = (mode == MODE_LIST) && (stat.fill != '0);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.exec      = 1'b0;
        cmd.list_step = 1'b0;
        cmd.list_last = (idx_reg == stat.fill - FILL_W'(1));
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (start_list)
                    begin
                        state_next = ST_LIST;
                        idx_next   = '0;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_LIST:
            begin
                if (stat.slot_free)
                begin
                    cmd.list_step = 1'b1;
                    idx_next      = idx_reg + FILL_W'(1);
                    if (cmd.list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `PLE_ASSERT_NOW(a_no_req_while_list, state_reg == ST_LIST, !in_ready,
                    "request taken while listing")
    `PLE_ASSERT_NEXT(a_list_ends_idle, cmd.list_step && cmd.list_last,
                     state_reg == ST_IDLE, "listing did not return to idle")
    `PLE_ASSERT_NOW(a_idx_in_range, state_reg == ST_LIST, idx_reg < stat.fill,
                    "list index beyond fill")

endmodule

// ===== sv/ple_dp.sv =====
`include "positional_list_engine_unit_assert.svh"

module ple_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ple_pkg::mode_t                        mode,
    input  logic signed [ple_pkg::DATA_W-1:0]     value,
    input  logic [ple_pkg::POS_W-1:0]             position,
    input  ple_pkg::cmd_t                         cmd,
    output ple_pkg::stat_t                        stat,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ple_pkg::DATA_W-1:0]     element,
    output logic                                  has_element,
    output ple_pkg::status_t                      status,
    output logic [ple_pkg::CNT_W-1:0]             item_count,
    output logic                                  last
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] cells_reg  [DEPTH];
    logic signed [DATA_W-1:0] cells_next [DEPTH];
    logic [FILL_W-1:0]        fill_reg, fill_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] element_reg;
    logic                     has_reg;
    status_t                  status_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     last_reg;

    logic              do_ins, do_del;
    logic [FILL_W-1:0] idx;
    status_t           st;
    logic              full, empty;
    logic [CMP_W-1:0]  pos_x, fill_x;

    assign full   = (fill_reg == FILL_W'(DEPTH));
    assign empty  = (fill_reg == '0);
    assign pos_x  = CMP_W'(position);
    assign fill_x = CMP_W'(fill_reg);

    always_comb
    begin
        do_ins = 1'b0;
        do_del = 1'b0;
        idx    = '0;
        st     = STAT_OK;
        case (mode)
            MODE_INS_FRONT:
            begin
                if (full) st = STAT_FULL;
                else      do_ins = 1'b1;
            end
            MODE_INS_BACK:
            begin
                idx = fill_reg;
                if (full) st = STAT_FULL;
                else      do_ins = 1'b1;
            end
            MODE_INS_POS:
            begin
                idx = FILL_W'(position - POS_W'(1));
                if (pos_x == '0 || pos_x > fill_x + CMP_W'(1)) st = STAT_BADPOS;
                else if (full)                                st = STAT_FULL;
                else                                          do_ins = 1'b1;
            end
            MODE_DEL_FRONT:
            begin
                if (empty) st = STAT_EMPTY;
                else       do_del = 1'b1;
            end
            MODE_DEL_BACK:
            begin
                idx = fill_reg - FILL_W'(1);
                if (empty) st = STAT_EMPTY;
                else       do_del = 1'b1;
            end
            MODE_DEL_POS:
            begin
                idx = FILL_W'(position - POS_W'(1));
                if (pos_x == '0 || pos_x > fill_x) st = STAT_BADPOS;
                else                               do_del = 1'b1;
            end
            default:
            begin
                st = STAT_OK;
            end
        endcase
    end

    // Parallel shift for insert/delete; listing rotates the live part of the list.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (cmd.exec && do_ins)
            begin
                if (FILL_W'(i) == idx)
                    cells_next[i] = value;
                else if (i > 0 && FILL_W'(i) > idx)
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
            end
            else if (cmd.exec && do_del)
            begin
                if (i < DEPTH - 1 && FILL_W'(i) >= idx)
                    cells_next[i] = cells_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
            else if (cmd.list_step)
            begin
                if (FILL_W'(i) == fill_reg - FILL_W'(1))
                    cells_next[i] = cells_reg[0];
                else if (i < DEPTH - 1 && FILL_W'(i) < fill_reg - FILL_W'(1))
                    cells_next[i] = cells_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.exec && do_ins) fill_next = fill_reg + FILL_W'(1);
        if (cmd.exec && do_del) fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            cells_reg[i] <= cells_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.exec || cmd.list_step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            element_reg <= '0;
            has_reg     <= 1'b0;
            status_reg  <= st;
            count_reg   <= CNT_W'(fill_next);
            last_reg    <= 1'b1;
        end
        else if (cmd.list_step)
        begin
            element_reg <= cells_reg[0];
            has_reg     <= 1'b1;
            status_reg  <= STAT_OK;
            count_reg   <= CNT_W'(fill_reg);
            last_reg    <= cmd.list_last;
        end
    end

    assign stat.fill      = fill_reg;
    assign stat.slot_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign element     = element_reg;
    assign has_element = has_reg;
    assign status      = status_reg;
    assign item_count  = count_reg;
    assign last        = last_reg;

    `PLE_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(DEPTH),
                    "fill beyond depth")
    `PLE_ASSERT_NOW(a_one_cmd, cmd.exec || cmd.list_step,
                    !(cmd.exec && cmd.list_step) && stat.slot_free,
                    "command issued without free output slot")
    `PLE_ASSERT_NEXT(a_list_keeps_fill, cmd.list_step, $stable(fill_reg) && out_valid_reg,
                     "listing changed fill or lost its request")

endmodule

// ===== sv/positional_list_engine_unit.sv =====
// Ordered list of up to 64 signed 32-bit values with insert/delete at front, back
// or a 1-based position, and a list request that streams the contents front to
// back with tlast on the final element. Insert and delete requests may arrive back
// to back while m_tready stays high: every cell shifts in parallel and the single
// response sits in the output register. While that response waits, s_tready is
// low; a new request is taken at the earliest in the cycle the response is
// accepted. A list request first moves the control into its list state, then
// streams one element per step while the output is free, as the cell array rotates
// through its front cell; an empty list answers with a single response. Every
// response carries the count.
module positional_list_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[2:0], value[34:3], position[41:35], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // element[31:0], status[33:32], item_count[40:34], pad
    output logic        m_tuser,   // has_element
    output logic        m_tlast
);
    import ple_pkg::*;

    mode_t                    mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    cmd_t                     cmd;
    stat_t                    stat;
    logic signed [DATA_W-1:0] element;
    status_t                  status;
    logic [CNT_W-1:0]         item_count;

    assign mode     = mode_t'(s_tdata[2:0]);
    assign value    = s_tdata[34:3];
    assign position = s_tdata[41:35];

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .value       (value),
        .position    (position),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .element     (element),
        .has_element (m_tuser),
        .status      (status),
        .item_count  (item_count),
        .last        (m_tlast)
    );

    assign m_tdata = {7'd0, item_count, status, element};

endmodule
